// ----- rtl/core/salct_pkg.sv -----
package salct_pkg;

    // Fixed field widths of the access and result transactions.
    localparam int ADDR_W = 64;
    localparam int TAG_W  = 64;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int WAY_OUT_W = 2;

    // Set index before the modulo: index_bits is at most 15 once masked to 4 bits.
    localparam int IDX_W = 15;
    // Reciprocal scaling for the index modulo by the set count.
    localparam int RECIP_SHIFT = 30;

    // Default geometry handed to the top level.
    localparam int DEF_WAYS      = 4;
    localparam int DEF_SETS      = 256;
    localparam int DEF_AGE_WIDTH = 32;

    // Access modes.
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RESET_OFFSET_BITS = 4'd5;
    localparam logic [CFG_W-1:0] RESET_INDEX_BITS  = 4'd8;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_UPDATE
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic read;
        logic update;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } ctl_status_t;

endpackage

// ----- rtl/core/salct_ctrl.sv -----
module salct_ctrl
    import salct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // State register and result-valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_INDEX:
            begin
                cmd.read = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result becomes valid on update and drops once the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/salct_datapath.sv -----
module salct_datapath
    import salct_pkg::*;
#(
    parameter int WAYS      = DEF_WAYS,
    parameter int SETS      = DEF_SETS,
    parameter int AGE_WIDTH = DEF_AGE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_cmd_t             cmd,
    output ctl_status_t          status,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ADDR_W-1:0]    address,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic                 evicted,
    output logic                 invalid_cmd,
    output logic [CNT_W-1:0]     miss_count,
    output logic [CNT_W-1:0]     access_count,
    output logic [CNT_W-1:0]     read_miss_count,
    output logic [CNT_W-1:0]     read_count,
    output logic [CNT_W-1:0]     write_miss_count,
    output logic [CNT_W-1:0]     write_count
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'(1) << RECIP_SHIFT) / SETS);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Line stores: one row per set, all ways side by side.
    logic [WAYS-1:0][TAG_W-1:0]     tag_mem   [SETS];
    logic [WAYS-1:0][AGE_WIDTH-1:0] age_mem   [SETS];
    logic [WAYS-1:0]                valid_mem [SETS];

    logic [CFG_W-1:0] offset_bits_reg;
    logic [CFG_W-1:0] index_bits_reg;

    logic [SET_W-1:0] clr_idx_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  quot_reg;
    logic [SET_W-1:0]  set_reg;

    logic [WAYS-1:0][TAG_W-1:0]     rd_tag_reg;
    logic [WAYS-1:0][AGE_WIDTH-1:0] rd_age_reg;
    logic [WAYS-1:0]                rd_valid_reg;

    logic [ADDR_W-1:0] shifted;
    logic [IDX_W:0]    idx_mask;
    logic [IDX_W-1:0]  idx_next;
    logic [PROD_W-1:0] quot_prod;
    logic [31:0]       quot_times_sets;
    logic [31:0]       rem_raw;
    logic [31:0]       rem_fix;
    logic [SET_W-1:0]  set_next;

    logic                           is_invalid;
    logic                           is_read;
    logic                           hit_found;
    logic [WAY_W-1:0]               hit_way;
    logic                           free_found;
    logic [WAY_W-1:0]               free_way;
    logic [WAY_W-1:0]               old_way;
    logic [AGE_WIDTH-1:0]           old_age;
    logic [WAY_W-1:0]               way_sel;
    logic [WAYS-1:0][TAG_W-1:0]     new_tag;
    logic [WAYS-1:0][AGE_WIDTH-1:0] new_age;
    logic [WAYS-1:0]                new_valid;
    logic                           evict_next;

    logic [CNT_W-1:0] miss_total_reg;
    logic [CNT_W-1:0] access_total_reg;
    logic [CNT_W-1:0] read_miss_total_reg;
    logic [CNT_W-1:0] read_total_reg;
    logic [CNT_W-1:0] write_miss_total_reg;
    logic [CNT_W-1:0] write_total_reg;

    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_used_reg;
    logic                 evicted_reg;
    logic                 invalid_cmd_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= RESET_OFFSET_BITS;
            index_bits_reg  <= RESET_INDEX_BITS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clearing pass over all sets after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clear)
            clr_idx_reg <= clr_idx_reg + 1'b1;
    end

    assign status.clear_last = (clr_idx_reg == SET_W'(SETS - 1));

    // Address split and the first half of the set modulo.
    always_comb
    begin
        shifted   = address >> offset_bits_reg;
        idx_mask  = ((IDX_W + 1)'(1) << index_bits_reg) - 1'b1;
        idx_next  = shifted[IDX_W-1:0] & idx_mask[IDX_W-1:0];
        quot_prod = PROD_W'(idx_next) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            tag_reg  <= shifted >> index_bits_reg;
            idx_reg  <= idx_next;
            quot_reg <= quot_prod[RECIP_SHIFT +: IDX_W];
        end
    end

    // Remainder from the estimated quotient, which is low by at most one.
    always_comb
    begin
        quot_times_sets = 32'(quot_reg) * 32'(SETS);
        rem_raw         = 32'(idx_reg) - quot_times_sets;
        rem_fix         = (rem_raw >= 32'(SETS)) ? (rem_raw - 32'(SETS)) : rem_raw;
        set_next        = SET_W'(rem_fix);
    end

    // Registered read of the selected set.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            set_reg      <= set_next;
            rd_tag_reg   <= tag_mem[set_next];
            rd_age_reg   <= age_mem[set_next];
            rd_valid_reg <= valid_mem[set_next];
        end
    end

    // Lookup, aging and replacement choice over the ways of the set.
    always_comb
    begin
        is_invalid = (mode_reg != MODE_READ) && (mode_reg != MODE_WRITE);
        is_read    = (mode_reg == MODE_READ);
        new_tag    = rd_tag_reg;
        new_valid  = rd_valid_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_valid_reg[w] && (rd_age_reg[w] != AGE_MAX))
                new_age[w] = rd_age_reg[w] + 1'b1;
            else
                new_age[w] = rd_age_reg[w];
        end

        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_valid_reg[w] && (rd_tag_reg[w] == tag_reg))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end

        free_found = 1'b0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!rd_valid_reg[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        // Oldest line by aged value; strict compare keeps the lowest way on ties.
        old_way = '0;
        old_age = new_age[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (new_age[w] > old_age)
            begin
                old_age = new_age[w];
                old_way = WAY_W'(w);
            end
        end

        way_sel    = '0;
        evict_next = 1'b0;
        if (!is_invalid)
        begin
            if (hit_found)
            begin
                way_sel          = hit_way;
                new_age[hit_way] = '0;
            end
            else
            begin
                way_sel            = free_found ? free_way : old_way;
                evict_next         = !free_found;
                new_valid[way_sel] = 1'b1;
                new_tag[way_sel]   = tag_reg;
                new_age[way_sel]   = '0;
            end
        end
    end

    // Memory write port: clearing pass or write-back of the updated set.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            tag_mem[clr_idx_reg]   <= '0;
            age_mem[clr_idx_reg]   <= '0;
            valid_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.update)
        begin
            tag_mem[set_reg]   <= new_tag;
            age_mem[set_reg]   <= new_age;
            valid_mem[set_reg] <= new_valid;
        end
    end

    // Saturating statistics counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_total_reg       <= '0;
            access_total_reg     <= '0;
            read_miss_total_reg  <= '0;
            read_total_reg       <= '0;
            write_miss_total_reg <= '0;
            write_total_reg      <= '0;
        end
        else if (cmd.update && !is_invalid)
        begin
            if (access_total_reg != CNT_MAX)
                access_total_reg <= access_total_reg + 1'b1;
            if (is_read && (read_total_reg != CNT_MAX))
                read_total_reg <= read_total_reg + 1'b1;
            if (!is_read && (write_total_reg != CNT_MAX))
                write_total_reg <= write_total_reg + 1'b1;
            if (!hit_found)
            begin
                if (miss_total_reg != CNT_MAX)
                    miss_total_reg <= miss_total_reg + 1'b1;
                if (is_read && (read_miss_total_reg != CNT_MAX))
                    read_miss_total_reg <= read_miss_total_reg + 1'b1;
                if (!is_read && (write_miss_total_reg != CNT_MAX))
                    write_miss_total_reg <= write_miss_total_reg + 1'b1;
            end
        end
    end

    // Result register for the per-access flags.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg         <= !is_invalid && hit_found;
            way_used_reg    <= WAY_OUT_W'(way_sel);
            evicted_reg     <= evict_next;
            invalid_cmd_reg <= is_invalid;
        end
    end

    assign hit              = hit_reg;
    assign way_used         = way_used_reg;
    assign evicted          = evicted_reg;
    assign invalid_cmd      = invalid_cmd_reg;
    assign miss_count       = miss_total_reg;
    assign access_count     = access_total_reg;
    assign read_miss_count  = read_miss_total_reg;
    assign read_count       = read_total_reg;
    assign write_miss_count = write_miss_total_reg;
    assign write_count      = write_total_reg;

endmodule

// ----- rtl/core/set_assoc_lru_cache_tags.sv -----
// Tag-only set-associative cache with least-recently-used replacement.
// Access transactions (mode, address) enter on in_valid/in_ready. Each one
// produces exactly one result transaction on out_valid/out_ready carrying
// the hit, way, eviction and invalid-command flags plus the running
// saturating counters. Configuration writes (offset_bits, index_bits) use
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Each access passes the controller sequence of accept, set-index reduction
// with memory read, and compare/write-back, which loads the result register.
// The write-back and result load wait while the result register still holds
// a result the receiver has not taken; a result is held stable until taken,
// and in_ready stays low until the pending access has written back.
// Reset: the counters clear and the configuration returns to 5 offset bits
// and 8 index bits. A clearing pass then zeroes one set per cycle over all
// sets, with in_ready low; configuration writes are still taken.
module set_assoc_lru_cache_tags
    import salct_pkg::*;
#(
    parameter int WAYS      = DEF_WAYS,
    parameter int SETS      = DEF_SETS,
    parameter int AGE_WIDTH = DEF_AGE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic                 evicted,
    output logic                 invalid_cmd,
    output logic [CNT_W-1:0]     miss_count,
    output logic [CNT_W-1:0]     access_count,
    output logic [CNT_W-1:0]     read_miss_count,
    output logic [CNT_W-1:0]     read_count,
    output logic [CNT_W-1:0]     write_miss_count,
    output logic [CNT_W-1:0]     write_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Sequencer for clearing, accept, read and write-back.
    salct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Line stores, lookup logic and counters.
    salct_datapath #(
        .WAYS      (WAYS),
        .SETS      (SETS),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .mode             (mode),
        .address          (address),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .hit              (hit),
        .way_used         (way_used),
        .evicted          (evicted),
        .invalid_cmd      (invalid_cmd),
        .miss_count       (miss_count),
        .access_count     (access_count),
        .read_miss_count  (read_miss_count),
        .read_count       (read_count),
        .write_miss_count (write_miss_count),
        .write_count      (write_count)
    );

endmodule
